// ===== rtl/ssa_pkg.sv =====
// Shared types, constants and class tables of the slab slot allocator.
`timescale 1ns / 1ps

package ssa_pkg;

  localparam int NUM_CLASSES      = 10;
  localparam int PAGE_BYTES_DEF   = 64 * 1024;
  localparam int FRAMES_DEF       = 8;
  localparam int HEADER_BYTES_DEF = 48;

  localparam int ADDR_W   = 48;
  localparam int XADDR_W  = 50;   // holds base plus the whole frame region
  localparam int SIZE_W   = 32;
  localparam int CLS_W    = 4;
  localparam int SLOT_W   = 10;   // largest slot is 512 bytes
  localparam int CNT_W    = 16;
  localparam int STAMP_W  = 32;
  localparam int KEEP_W   = 4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BIG      = 3'd1,
    ST_NOFRAME  = 3'd2,
    ST_NOTIN    = 3'd3,
    ST_NULL     = 3'd4,
    ST_MISALIGN = 3'd5
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_REGION_BASE = 1'b0,
    REG_KEEP_EMPTY  = 1'b1
  } cfg_reg_t;

  // Divider handshake status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Slot size in bytes of each class
  function automatic logic [SLOT_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
    logic [SLOT_W-1:0] r;
    case (c)
      4'd0:    r = 10'd16;
      4'd1:    r = 10'd32;
      4'd2:    r = 10'd48;
      4'd3:    r = 10'd64;
      4'd4:    r = 10'd96;
      4'd5:    r = 10'd128;
      4'd6:    r = 10'd192;
      4'd7:    r = 10'd256;
      4'd8:    r = 10'd384;
      default: r = 10'd512;
    endcase
    return r;
  endfunction

  // Smallest class that holds the size; top bit flags a size over 512 bytes
  function automatic logic [CLS_W:0] class_of(input logic [SIZE_W-1:0] size);
    logic [CLS_W:0] r;
    r = {1'b1, CLS_W'(0)};
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (size <= SIZE_W'(class_bytes(CLS_W'(i)))) begin
        r = {1'b0, CLS_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/ssa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered and valid in the next cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ssa_div.sv =====
// Serial restoring divider by a slot size, one quotient bit per cycle.
`timescale 1ns / 1ps

module ssa_div #(
  parameter int DW = ssa_pkg::XADDR_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DW-1:0]               dividend,
  input  logic [ssa_pkg::SLOT_W-1:0]  divisor,
  output ssa_pkg::div_stat_t          stat,
  output logic [DW-1:0]               quot,
  output logic [ssa_pkg::SLOT_W-1:0]  rem
);

  localparam int SW = ssa_pkg::SLOT_W;
  localparam int NW = $clog2(DW + 1);

  logic [DW-1:0] shreg;
  logic [SW-1:0] acc;
  logic [SW-1:0] dsr;
  logic [NW-1:0] cnt;
  logic          done;
  logic [SW:0]   trial;
  logic          ge;

  assign trial = {acc, shreg[DW-1]};
  assign ge    = trial >= {1'b0, dsr};

  // Load on start, then shift one bit of the dividend in per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= NW'(DW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      acc   <= '0;
      dsr   <= divisor;
    end else if (cnt != '0) begin
      acc   <= ge ? SW'(trial - {1'b0, dsr}) : SW'(trial);
      shreg <= {shreg[DW-2:0], ge};
    end
  end

  assign stat.busy = cnt != '0;
  assign stat.done = done;
  assign quot      = shreg;
  assign rem       = acc;

endmodule

// ===== rtl/slab_slot_allocator_core.sv =====
// Slab slot allocator: sequencer, frame table, class counters and result register.
// Most of the work is done by the shared serial divider (DW = 50), one quotient bit per
// cycle, and by the frame scan through the frame table RAM read port, for an allocation
// and for a free. Requests that are answered at once (too large, null) skip both.
// One request at a time.
// Reset (synchronous, rst high) clears all frames, class counts and the insert counter;
// the slot link memory and the frame table RAM need no clearing.
`timescale 1ns / 1ps

module slab_slot_allocator_core #(
  parameter int PAGE_BYTES   = ssa_pkg::PAGE_BYTES_DEF,
  parameter int FRAMES       = ssa_pkg::FRAMES_DEF,
  parameter int HEADER_BYTES = ssa_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // req_size[31:0], addr_in[79:32]
  input  logic [0:0]  s_axis_tuser,   // opcode[0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // addr_out[47:0], class_used[63:48], class_peak[79:64]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  localparam int XW   = ssa_pkg::XADDR_W;
  localparam int AW   = ssa_pkg::ADDR_W;
  localparam int SW   = ssa_pkg::SLOT_W;
  localparam int CLW  = ssa_pkg::CLS_W;
  localparam int NW   = ssa_pkg::CNT_W;
  localparam int TW   = ssa_pkg::STAMP_W;
  localparam int KW   = ssa_pkg::KEEP_W;
  localparam int NCL  = ssa_pkg::NUM_CLASSES;

  localparam int SLOTS_MAX = PAGE_BYTES / 16;
  localparam int CW        = $clog2(SLOTS_MAX + 1);
  localparam int LW        = $clog2(SLOTS_MAX);
  localparam int FW        = FRAMES > 1 ? $clog2(FRAMES) : 1;
  localparam int EW        = $clog2(FRAMES + 1);
  localparam int LDEPTH    = FRAMES * SLOTS_MAX;
  localparam int LAW       = $clog2(LDEPTH);

  localparam logic [XW-1:0] PAGE_X = XW'(PAGE_BYTES);
  localparam logic [XW-1:0] HDR_X  = XW'(HEADER_BYTES);

  typedef struct packed {
    logic [CLW-1:0] cls;
    logic [TW-1:0]  stamp;
    logic [CW-1:0]  used;
    logic [CW-1:0]  fresh;
    logic [LW-1:0]  head;
  } frec_t;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_MOD    = 15'h0002,
    S_SCAN_A = 15'h0004,
    S_SCAN_B = 15'h0008,
    S_PICK   = 15'h0010,
    S_TOT    = 15'h0020,
    S_TOT_W  = 15'h0040,
    S_TAKE   = 15'h0080,
    S_LINK_A = 15'h0100,
    S_LINK_B = 15'h0200,
    S_FQ_W   = 15'h0400,
    S_FCHK   = 15'h0800,
    S_EMP_A  = 15'h1000,
    S_EMP_B  = 15'h2000,
    S_EMIT   = 15'h4000
  } state_t;

  // Page size modulo a class slot size
  function automatic logic [SW-1:0] page_mod(input logic [CLW-1:0] c);
    logic [SW-1:0] r;
    case (c)
      4'd0:    r = SW'(PAGE_BYTES % 16);
      4'd1:    r = SW'(PAGE_BYTES % 32);
      4'd2:    r = SW'(PAGE_BYTES % 48);
      4'd3:    r = SW'(PAGE_BYTES % 64);
      4'd4:    r = SW'(PAGE_BYTES % 96);
      4'd5:    r = SW'(PAGE_BYTES % 128);
      4'd6:    r = SW'(PAGE_BYTES % 192);
      4'd7:    r = SW'(PAGE_BYTES % 256);
      4'd8:    r = SW'(PAGE_BYTES % 384);
      default: r = SW'(PAGE_BYTES % 512);
    endcase
    return r;
  endfunction

  state_t state;

  // configuration
  logic [AW-1:0] region_base;
  logic [KW-1:0] keep_empty;

  // request
  logic             op_q;
  logic [CLW-1:0]   cls_q;
  logic [AW-1:0]    addr_q;
  logic [CLW:0]     cls_dec;

  // frame state in flops
  logic [FRAMES-1:0] live;
  logic [FRAMES-1:0] full;
  logic [NW-1:0]     cls_used [NCL];
  logic [NW-1:0]     cls_peak [NCL];
  logic [TW-1:0]     counter;

  // scan walker
  logic [FW-1:0] scan_f;
  logic [XW-1:0] fbase;
  logic [SW-1:0] frem;
  logic          have_best, have_dead;
  logic [FW-1:0] best_f, dead_f;
  logic [XW-1:0] best_base, dead_base;
  logic [SW-1:0] best_rem, dead_rem;
  logic [TW-1:0] best_age;
  logic [EW-1:0] empties;

  // selected frame
  logic [FW-1:0] cur_f;
  logic [XW-1:0] cur_base;
  logic [SW-1:0] cur_rem;
  logic          new_frame;
  logic [CW-1:0] total;
  logic [CW-1:0] fq;
  logic [SW-1:0] fr;
  frec_t         rec;

  // result
  logic [AW-1:0]         res_addr;
  ssa_pkg::status_t      res_status;
  logic                  res_zero;

  // divider
  logic                  div_go;
  logic [XW-1:0]         div_in;
  ssa_pkg::div_stat_t    div_stat;
  logic [XW-1:0]         div_quot;
  logic [SW-1:0]         div_rem;

  // memories
  logic                  fr_we;
  frec_t                 fr_wdata;
  logic [$bits(frec_t)-1:0] fr_rdata_raw;
  frec_t                 fr_rdata;
  logic                  ln_we;
  logic [LAW-1:0]        ln_waddr;
  logic [LAW-1:0]        link_raddr;
  logic [LW-1:0]         link_rdata;

  // datapath
  logic [SW-1:0]  slot;
  logic [SW-1:0]  scan_pad, cur_pad;
  logic [XW-1:0]  scan_ds, scan_end, cur_ds, cur_end, span;
  logic [SW:0]    rsum;
  logic [SW-1:0]  frem_step;
  logic [TW-1:0]  age;
  logic           scan_last;
  logic           scan_hit;
  logic [CW:0]    busy_cnt;
  logic           stacked_pos;
  logic           tk_fire;
  logic [LW-1:0]  tk_idx;
  frec_t          tk_rec;
  frec_t          new_rec;
  frec_t          fc_rec;
  logic [NW-1:0]  used_inc, used_dec;
  logic [XW-1:0]  tk_addr;
  logic           out_free;

  assign cls_dec = ssa_pkg::class_of(s_axis_tdata[31:0]);
  assign slot    = ssa_pkg::class_bytes(cls_q);
  assign fr_rdata = frec_t'(fr_rdata_raw);

  // Data start and end of the scanned and of the selected frame
  assign scan_pad  = (frem == '0) ? '0 : slot - frem;
  assign scan_ds   = fbase + HDR_X + XW'(scan_pad);
  assign scan_end  = fbase + PAGE_X;
  assign cur_pad   = (cur_rem == '0) ? '0 : slot - cur_rem;
  assign cur_ds    = cur_base + HDR_X + XW'(cur_pad);
  assign cur_end   = cur_base + PAGE_X;
  assign span      = (cur_ds < cur_end) ? cur_end - cur_ds : '0;

  // Step the data-start remainder to the next frame
  assign rsum      = {1'b0, frem} + {1'b0, page_mod(cls_q)};
  assign frem_step = (rsum >= {1'b0, slot}) ? SW'(rsum - {1'b0, slot}) : SW'(rsum);

  assign age       = counter - fr_rdata.stamp;
  assign scan_last = scan_f == FW'(FRAMES - 1);
  assign scan_hit  = live[scan_f] && (fr_rdata.cls == cls_q) &&
                     ({2'b0, addr_q} >= scan_ds) && ({2'b0, addr_q} < scan_end);

  // Slot take: freed stack first, then fresh slots from the top down
  assign busy_cnt    = {1'b0, rec.fresh} + {1'b0, rec.used};
  assign stacked_pos = {1'b0, total} > busy_cnt;
  assign tk_fire     = (state == S_LINK_B) ||
                       ((state == S_TAKE) && !stacked_pos && (rec.fresh != '0));
  assign tk_idx      = (state == S_LINK_B) ? rec.head : LW'(rec.fresh - 1'b1);

  always_comb begin
    tk_rec       = rec;
    tk_rec.used  = rec.used + 1'b1;
    if (state == S_LINK_B) begin
      tk_rec.head = link_rdata;
    end else begin
      tk_rec.fresh = rec.fresh - 1'b1;
    end
  end

  assign tk_addr  = cur_ds + XW'(tk_idx * slot);
  assign used_inc = (cls_used[cls_q] == '1) ? cls_used[cls_q] : cls_used[cls_q] + 1'b1;
  assign used_dec = (cls_used[cls_q] == '0) ? '0 : cls_used[cls_q] - 1'b1;

  always_comb begin
    new_rec.cls   = cls_q;
    new_rec.stamp = counter;
    new_rec.used  = '0;
    new_rec.fresh = CW'(div_quot);
    new_rec.head  = '0;
  end

  always_comb begin
    fc_rec       = rec;
    fc_rec.head  = LW'(fq);
    fc_rec.used  = rec.used - 1'b1;
    if (full[cur_f]) begin
      fc_rec.stamp = counter;
    end
  end

  // Frame table write select
  always_comb begin
    fr_we    = 1'b0;
    fr_wdata = tk_rec;
    if (tk_fire) begin
      fr_we = 1'b1;
    end else if ((state == S_TOT_W) && div_stat.done && (op_q == ssa_pkg::OP_ALLOC) &&
                 new_frame) begin
      fr_we    = 1'b1;
      fr_wdata = new_rec;
    end else if ((state == S_FCHK) && (fr == '0) && (fq < total) && (rec.used != '0)) begin
      fr_we    = 1'b1;
      fr_wdata = fc_rec;
    end
  end

  assign ln_we    = fr_we && (state == S_FCHK);
  assign ln_waddr = LAW'(cur_f) * LAW'(SLOTS_MAX) + LAW'(fq);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = state == S_IDLE;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      keep_empty  <= KW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        ssa_pkg::REG_REGION_BASE: region_base <= cfg_data;
        ssa_pkg::REG_KEEP_EMPTY:  keep_empty  <= cfg_data[KW-1:0];
        default:                  region_base <= region_base;
      endcase
    end
  end

  // Sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      live          <= '0;
      full          <= '0;
      counter       <= '0;
      div_go        <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < NCL; i++) begin
        cls_used[i] <= '0;
        cls_peak[i] <= '0;
      end
    end else begin
      div_go <= 1'b0;
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      // Count a slot taken in the request's class
      if (tk_fire) begin
        full[cur_f]     <= tk_rec.used >= total;
        cls_used[cls_q] <= used_inc;
        if (used_inc > cls_peak[cls_q]) begin
          cls_peak[cls_q] <= used_inc;
        end
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser[0] == ssa_pkg::OP_FREE && s_axis_tdata[79:32] == '0) begin
              state <= S_EMIT;
            end else if (cls_dec[CLW]) begin
              state <= S_EMIT;
            end else begin
              div_go <= 1'b1;
              state  <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (div_stat.done) begin
            state <= S_SCAN_A;
          end
        end
        S_SCAN_A: state <= S_SCAN_B;
        S_SCAN_B: begin
          if (op_q == ssa_pkg::OP_FREE && scan_hit) begin
            div_go <= 1'b1;
            state  <= S_FQ_W;
          end else if (scan_last) begin
            state <= (op_q == ssa_pkg::OP_FREE) ? S_EMIT : S_PICK;
          end else begin
            state <= S_SCAN_A;
          end
        end
        S_PICK: state <= (have_best || have_dead) ? S_TOT : S_EMIT;
        S_TOT: begin
          div_go <= 1'b1;
          state  <= S_TOT_W;
        end
        S_TOT_W: begin
          if (div_stat.done) begin
            if (op_q == ssa_pkg::OP_FREE) begin
              state <= S_FCHK;
            end else begin
              if (new_frame) begin
                live[cur_f] <= 1'b1;
                full[cur_f] <= 1'b0;
                counter     <= counter + 1'b1;
              end
              state <= S_TAKE;
            end
          end
        end
        S_TAKE: begin
          if (stacked_pos) begin
            state <= S_LINK_A;
          end else if (rec.fresh != '0) begin
            state <= S_EMIT;
          end else if (!new_frame && have_dead) begin
            state <= S_TOT;
          end else begin
            state <= S_EMIT;
          end
        end
        S_LINK_A: state <= S_LINK_B;
        S_LINK_B: state <= S_EMIT;
        S_FQ_W: begin
          if (div_stat.done) begin
            state <= S_TOT;
          end
        end
        S_FCHK: begin
          if (fr_we) begin
            cls_used[cls_q] <= used_dec;
            if (full[cur_f]) begin
              full[cur_f] <= 1'b0;
              counter     <= counter + 1'b1;
            end
            state <= (fc_rec.used == '0) ? S_EMP_A : S_EMIT;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMP_A: state <= S_EMP_B;
        S_EMP_B: begin
          if (scan_last) begin
            if (32'(empties) + ((live[scan_f] && fr_rdata.cls == cls_q && !full[scan_f] &&
                fr_rdata.used == '0) ? 32'd1 : 32'd0) > 32'(keep_empty)) begin
              live[cur_f] <= 1'b0;
              full[cur_f] <= 1'b0;
            end
            state <= S_EMIT;
          end else begin
            state <= S_EMP_A;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sequencer datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_q       <= s_axis_tuser[0];
        cls_q      <= cls_dec[CLW-1:0];
        addr_q     <= s_axis_tdata[79:32];
        res_addr   <= '0;
        res_zero   <= cls_dec[CLW];
        div_in     <= XW'(s_axis_tdata[79:32] == s_axis_tdata[79:32] ? region_base : '0) +
                      HDR_X;
        if (s_axis_tuser[0] == ssa_pkg::OP_FREE && s_axis_tdata[79:32] == '0) begin
          res_status <= ssa_pkg::ST_NULL;
        end else begin
          res_status <= ssa_pkg::ST_BIG;
        end
      end
      S_MOD: begin
        frem      <= div_rem;
        fbase     <= XW'(region_base);
        scan_f    <= '0;
        have_best <= 1'b0;
        have_dead <= 1'b0;
      end
      S_SCAN_B: begin
        // Track the newest partial frame and the lowest unused frame
        if (live[scan_f] && fr_rdata.cls == cls_q && !full[scan_f] &&
            (!have_best || age < best_age)) begin
          have_best <= 1'b1;
          best_f    <= scan_f;
          best_base <= fbase;
          best_rem  <= frem;
          best_age  <= age;
        end
        if (!live[scan_f] && !have_dead) begin
          have_dead <= 1'b1;
          dead_f    <= scan_f;
          dead_base <= fbase;
          dead_rem  <= frem;
        end
        if (op_q == ssa_pkg::OP_FREE && scan_hit) begin
          cur_f    <= scan_f;
          cur_base <= fbase;
          cur_rem  <= frem;
          div_in   <= {2'b0, addr_q} - scan_ds;
        end else if (!scan_last) begin
          scan_f <= scan_f + 1'b1;
          fbase  <= fbase + PAGE_X;
          frem   <= frem_step;
        end else if (op_q == ssa_pkg::OP_FREE) begin
          res_status <= ssa_pkg::ST_NOTIN;
        end
      end
      S_PICK: begin
        if (have_best) begin
          cur_f     <= best_f;
          cur_base  <= best_base;
          cur_rem   <= best_rem;
          scan_f    <= best_f;
          new_frame <= 1'b0;
        end else begin
          cur_f     <= dead_f;
          cur_base  <= dead_base;
          cur_rem   <= dead_rem;
          new_frame <= 1'b1;
        end
        res_status <= ssa_pkg::ST_NOFRAME;
      end
      S_TOT: div_in <= span;
      S_TOT_W: begin
        if (div_stat.done) begin
          total <= CW'(div_quot);
          if (op_q == ssa_pkg::OP_ALLOC && new_frame) begin
            rec <= new_rec;
          end else begin
            rec <= fr_rdata;
          end
        end
      end
      S_TAKE: begin
        link_raddr <= LAW'(cur_f) * LAW'(SLOTS_MAX) + LAW'(rec.head);
        if (!stacked_pos && rec.fresh == '0 && !new_frame && have_dead) begin
          cur_f     <= dead_f;
          cur_base  <= dead_base;
          cur_rem   <= dead_rem;
          new_frame <= 1'b1;
        end
        if (tk_fire) begin
          res_addr   <= tk_addr[AW-1:0];
          res_status <= ssa_pkg::ST_OK;
        end
      end
      S_LINK_B: begin
        res_addr   <= tk_addr[AW-1:0];
        res_status <= ssa_pkg::ST_OK;
      end
      S_FQ_W: begin
        if (div_stat.done) begin
          fq <= CW'(div_quot);
          fr <= div_rem;
        end
      end
      S_FCHK: begin
        scan_f  <= '0;
        empties <= '0;
        if (fr != '0 || fq >= total) begin
          res_status <= ssa_pkg::ST_MISALIGN;
        end else begin
          res_status <= ssa_pkg::ST_OK;
        end
      end
      S_EMP_B: begin
        // Count empty frames of the class
        if (live[scan_f] && fr_rdata.cls == cls_q && !full[scan_f] && fr_rdata.used == '0) begin
          empties <= empties + 1'b1;
        end
        if (!scan_last) begin
          scan_f <= scan_f + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          m_axis_tdata[47:0]  <= res_addr;
          m_axis_tdata[63:48] <= res_zero ? '0 : cls_used[cls_q];
          m_axis_tdata[79:64] <= res_zero ? '0 : cls_peak[cls_q];
          m_axis_tuser        <= res_status;
        end
      end
      default: begin
        scan_f <= scan_f;
      end
    endcase
  end

  // Shared serial divider
  ssa_div #(
    .DW(XW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_in),
    .divisor  (slot),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Frame table: class, stamp, counts and freed-stack head of each frame
  ssa_ram #(
    .WIDTH($bits(frec_t)),
    .DEPTH(FRAMES)
  ) u_frames (
    .clk   (clk),
    .we    (fr_we),
    .waddr (cur_f),
    .wdata (fr_wdata),
    .raddr (scan_f),
    .rdata (fr_rdata_raw)
  );

  // Freed-slot links, one row of SLOTS_MAX entries per frame
  ssa_ram #(
    .WIDTH(LW),
    .DEPTH(LDEPTH)
  ) u_links (
    .clk   (clk),
    .we    (ln_we),
    .waddr (ln_waddr),
    .wdata (rec.head),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // The divider is only started when it is idle
  assert property (@(posedge clk) disable iff (rst) div_go |-> !div_stat.busy)
    else $error("divider started while busy");

  // One request at a time: no request is taken right after another
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while one is in work");

  // A too-large answer carries no class counts
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ssa_pkg::ST_BIG) |-> (m_axis_tdata[79:48] == '0))
    else $error("class counts on a too-large answer");

endmodule
